>>> rtl/nmea_sentence_framer_checker_defines.svh
// assertion macros for the nmea sentence framer checker
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define NSFC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nsfc assertion failed");

// property checked at every rising clock edge, reset included
`define NSFC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nsfc assertion failed");

`endif

>>> rtl/nsfc_pkg.sv
// types, character codes and helpers for the nmea sentence framer checker
`timescale 1ns / 1ps

package nsfc_pkg;

  // input item: one received character or a receiver error event
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       line_fault;
  } in_item_t;

  // result item: sentence status and running totals
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  sentence_kind;
    logic [7:0]  computed_sum;
    logic [6:0]  line_length;
    logic [31:0] bad_sum_count;
    logic [31:0] drop_count;
    logic [31:0] fault_count;
  } out_item_t;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
  localparam logic [1:0] STATUS_FAULT    = 2'd3;

  // sentence kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GGA   = 2'd1;
  localparam logic [1:0] KIND_RMC   = 2'd2;

  // kind flag bit positions
  localparam int unsigned KF_GGA   = 0;
  localparam int unsigned KF_RMC   = 1;
  localparam int unsigned KF_COMMA = 2;

  // character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_C      = 8'h43;

  // hex digit decode, bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

>>> rtl/nmea_sentence_framer_checker.sv
// nmea sentence framer and checksum checker, top level
// an accepted item passes the input register, then the result register, before its result is valid
// throughput: one item per cycle while no result stall holds it; the per-character update is combinational
// items that close no sentence and carry no line fault give no result; result stall holds both stages
// rst (synchronous, active high) clears sentence state, totals and both stage valids
`timescale 1ns / 1ps

module nmea_sentence_framer_checker #(
  parameter int MAX_LINE_CHARS = 127
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  nsfc_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output nsfc_pkg::out_item_t result
);

  localparam int CW = $clog2(MAX_LINE_CHARS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LINE_CHARS);

  // input stage
  logic               s0_valid;
  nsfc_pkg::in_item_t s0_item;
  logic               s1_ready;
  logic               s0_fire;

  // sentence state
  logic          in_sentence, in_sentence_next;
  logic [CW-1:0] char_count, char_count_next;
  logic [7:0]    running_xor, running_xor_next;
  logic          star_seen, star_seen_next;
  logic [1:0]    hex_seen, hex_seen_next;
  logic [7:0]    expected_sum, expected_sum_next;
  logic          hex_ok, hex_ok_next;
  logic          text_ended, text_ended_next;
  logic [2:0]    kind_flags, kind_flags_next;
  logic [31:0]   bad_total, bad_total_next;
  logic [31:0]   ovf_total, ovf_total_next;
  logic [31:0]   fault_total, fault_total_next;

  logic                emit;
  nsfc_pkg::out_item_t res_next;

  // handshake
  assign s1_ready   = !result_valid || !result_stall;
  assign s0_fire    = s0_valid && s1_ready;
  assign item_stall = s0_valid && !s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (!item_stall) begin
      s0_valid <= item_valid;
    end
    if (!item_stall) begin
      s0_item <= item;
    end
  end

  // per-item update
  always_comb begin
    logic [7:0] c;
    logic [4:0] nib;
    logic       ok;
    c                 = s0_item.rx_byte;
    nib               = nsfc_pkg::hex_nibble(c);
    ok                = 1'b0;
    in_sentence_next  = in_sentence;
    char_count_next   = char_count;
    running_xor_next  = running_xor;
    star_seen_next    = star_seen;
    hex_seen_next     = hex_seen;
    expected_sum_next = expected_sum;
    hex_ok_next       = hex_ok;
    text_ended_next   = text_ended;
    kind_flags_next   = kind_flags;
    bad_total_next    = bad_total;
    ovf_total_next    = ovf_total;
    fault_total_next  = fault_total;
    emit              = 1'b0;
    res_next          = '0;

    if (s0_item.line_fault) begin
      // receiver error abandons the sentence
      emit                 = 1'b1;
      res_next.status      = nsfc_pkg::STATUS_FAULT;
      res_next.line_length = in_sentence ? 7'(char_count) : 7'd0;
      in_sentence_next     = 1'b0;
      char_count_next      = '0;
      fault_total_next     = fault_total + 32'd1;
    end else if (c == nsfc_pkg::CH_DOLLAR) begin
      // start of a new sentence
      in_sentence_next  = 1'b1;
      char_count_next   = CW'(1);
      running_xor_next  = 8'd0;
      star_seen_next    = 1'b0;
      hex_seen_next     = 2'd0;
      expected_sum_next = 8'd0;
      hex_ok_next       = 1'b1;
      text_ended_next   = 1'b0;
      kind_flags_next   = 3'd0;
    end else if (!in_sentence || c == nsfc_pkg::CH_CR) begin
      // nothing to do
    end else if (c == nsfc_pkg::CH_LF) begin
      // end of sentence
      ok = star_seen && hex_seen == 2'd2 && hex_ok && running_xor == expected_sum;
      emit                  = 1'b1;
      res_next.computed_sum = running_xor;
      res_next.line_length  = 7'(char_count);
      in_sentence_next      = 1'b0;
      char_count_next       = '0;
      if (!ok) begin
        res_next.status = nsfc_pkg::STATUS_BAD_SUM;
        bad_total_next  = bad_total + 32'd1;
      end else begin
        res_next.status = nsfc_pkg::STATUS_OK;
        if (kind_flags[nsfc_pkg::KF_COMMA]) begin
          if (kind_flags[nsfc_pkg::KF_GGA]) begin
            res_next.sentence_kind = nsfc_pkg::KIND_GGA;
          end else if (kind_flags[nsfc_pkg::KF_RMC]) begin
            res_next.sentence_kind = nsfc_pkg::KIND_RMC;
          end
        end
      end
    end else if (char_count < MAX_CNT) begin
      // store one character
      char_count_next = char_count + CW'(1);
      if (text_ended) begin
        // text already closed by a zero byte
      end else if (c == nsfc_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end else if (star_seen) begin
        if (hex_seen != 2'd2) begin
          if (!nib[4]) begin
            hex_ok_next = 1'b0;
          end else begin
            expected_sum_next = {expected_sum[3:0], nib[3:0]};
          end
          hex_seen_next = hex_seen + 2'd1;
        end
      end else if (c == nsfc_pkg::CH_STAR) begin
        star_seen_next = 1'b1;
      end else begin
        running_xor_next = running_xor ^ c;
        if (char_count == CW'(3)) begin
          kind_flags_next = {1'b0, c == nsfc_pkg::CH_R, c == nsfc_pkg::CH_G};
        end else if (char_count == CW'(4)) begin
          if (c != nsfc_pkg::CH_G) kind_flags_next[nsfc_pkg::KF_GGA] = 1'b0;
          if (c != nsfc_pkg::CH_M) kind_flags_next[nsfc_pkg::KF_RMC] = 1'b0;
        end else if (char_count == CW'(5)) begin
          if (c != nsfc_pkg::CH_A) kind_flags_next[nsfc_pkg::KF_GGA] = 1'b0;
          if (c != nsfc_pkg::CH_C) kind_flags_next[nsfc_pkg::KF_RMC] = 1'b0;
        end else if (char_count == CW'(6) && c == nsfc_pkg::CH_COMMA) begin
          kind_flags_next[nsfc_pkg::KF_COMMA] = 1'b1;
        end
      end
    end else begin
      // line too long, drop it
      emit                 = 1'b1;
      res_next.status      = nsfc_pkg::STATUS_OVERFLOW;
      res_next.line_length = 7'(char_count);
      in_sentence_next     = 1'b0;
      char_count_next      = '0;
      ovf_total_next       = ovf_total + 32'd1;
    end

    res_next.bad_sum_count = bad_total_next;
    res_next.drop_count    = ovf_total_next;
    res_next.fault_count   = fault_total_next;
  end

  // sentence state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence  <= 1'b0;
      char_count   <= '0;
      running_xor  <= 8'd0;
      star_seen    <= 1'b0;
      hex_seen     <= 2'd0;
      expected_sum <= 8'd0;
      hex_ok       <= 1'b1;
      text_ended   <= 1'b0;
      kind_flags   <= 3'd0;
      bad_total    <= 32'd0;
      ovf_total    <= 32'd0;
      fault_total  <= 32'd0;
    end else if (s0_fire) begin
      in_sentence  <= in_sentence_next;
      char_count   <= char_count_next;
      running_xor  <= running_xor_next;
      star_seen    <= star_seen_next;
      hex_seen     <= hex_seen_next;
      expected_sum <= expected_sum_next;
      hex_ok       <= hex_ok_next;
      text_ended   <= text_ended_next;
      kind_flags   <= kind_flags_next;
      bad_total    <= bad_total_next;
      ovf_total    <= ovf_total_next;
      fault_total  <= fault_total_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_ready) begin
      result_valid <= s0_fire && emit;
    end
    if (s1_ready) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/nsfc_checker.sv
// port-level assertions for the nmea sentence framer checker and their bind
`timescale 1ns / 1ps
`include "nmea_sentence_framer_checker_defines.svh"

module nsfc_checker #(
  parameter int MAX_LINE_CHARS = 127
) (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input nsfc_pkg::in_item_t  item,
  input logic                result_valid,
  input logic                result_stall,
  input nsfc_pkg::out_item_t result
);

  logic in_stalled;
  logic res_stalled;
  logic res_not_ok;
  logic kind_none;
  logic res_ovf;
  logic ovf_shape;

  // terms of the properties below
  assign in_stalled  = item_valid && item_stall;
  assign res_stalled = result_valid && result_stall;
  assign res_not_ok  = result_valid && (result.status != nsfc_pkg::STATUS_OK);
  assign kind_none   = (result.sentence_kind == nsfc_pkg::KIND_OTHER);
  assign res_ovf     = result_valid && (result.status == nsfc_pkg::STATUS_OVERFLOW);
  assign ovf_shape   = (result.computed_sum == 8'd0) &&
                       (result.line_length == 7'(MAX_LINE_CHARS));

  // a stalled input item holds
  `NSFC_ASSERT(a_item_hold, clk, rst, in_stalled |=> item_valid && $stable(item))

  // a stalled result item holds
  `NSFC_ASSERT(a_result_hold, clk, rst, res_stalled |=> result_valid && $stable(result))

  // no result right after reset
  `NSFC_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !result_valid)

  // kind only reported with a valid checksum
  `NSFC_ASSERT(a_kind_only_ok, clk, rst, res_not_ok |-> kind_none)

  // dropped sentences carry no sum, their length is the limit
  `NSFC_ASSERT(a_overflow_len, clk, rst, res_ovf |-> ovf_shape)

endmodule

bind nmea_sentence_framer_checker nsfc_checker #(
  .MAX_LINE_CHARS(MAX_LINE_CHARS)
) u_nsfc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

>>> tb/tb.sv
// testbench for the nmea sentence framer checker: sentence traffic against a predictor
`timescale 1ns / 1ps

module tb;

  localparam int LINE_LIMIT = 127;
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1500;

  // extra character codes used by the predictor and the line builder
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;

  // predictor of sentence reports and queue of reports still owed by the block
  class sentence_predictor;
    bit                  in_sentence;
    int unsigned         held;
    logic [7:0]          xor_acc;
    bit                  star_seen;
    int unsigned         digits;
    logic [7:0]          sum_field;
    bit                  digits_ok;
    bit                  text_done;
    logic [2:0]          kind_flags;
    logic [31:0]         bad_total;
    logic [31:0]         overflow_total;
    logic [31:0]         fault_total;
    nsfc_pkg::out_item_t pending_reports[$];
    int unsigned         mismatches;

    function new();
      in_sentence    = 0;
      held           = 0;
      xor_acc        = '0;
      star_seen      = 0;
      digits         = 0;
      sum_field      = '0;
      digits_ok      = 1;
      text_done      = 0;
      kind_flags     = '0;
      bad_total      = '0;
      overflow_total = '0;
      fault_total    = '0;
      mismatches     = 0;
    endfunction

    // value of a hex digit of either case, -1 for anything else
    function int digit_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
      if (c >= nsfc_pkg::CH_A && c <= CH_F) return int'(c - nsfc_pkg::CH_A) + 10;
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      return -1;
    endfunction

    // one character stored in the open sentence
    function void store_char(logic [7:0] c);
      int unsigned pos;
      int          v;
      pos  = held;
      held = held + 1;
      if (text_done) return;
      if (c == nsfc_pkg::CH_NUL) begin
        text_done = 1;
        return;
      end
      if (star_seen) begin
        if (digits < 2) begin
          v = digit_value(c);
          if (v < 0) digits_ok = 0;
          else sum_field = {sum_field[3:0], 4'(v)};
          digits++;
        end
        return;
      end
      if (c == nsfc_pkg::CH_STAR) begin
        star_seen = 1;
        return;
      end
      xor_acc ^= c;
      case (pos)
        3: begin
          kind_flags = '0;
          kind_flags[nsfc_pkg::KF_GGA] = (c == nsfc_pkg::CH_G);
          kind_flags[nsfc_pkg::KF_RMC] = (c == nsfc_pkg::CH_R);
        end
        4: begin
          if (c != nsfc_pkg::CH_G) kind_flags[nsfc_pkg::KF_GGA] = 1'b0;
          if (c != nsfc_pkg::CH_M) kind_flags[nsfc_pkg::KF_RMC] = 1'b0;
        end
        5: begin
          if (c != nsfc_pkg::CH_A) kind_flags[nsfc_pkg::KF_GGA] = 1'b0;
          if (c != nsfc_pkg::CH_C) kind_flags[nsfc_pkg::KF_RMC] = 1'b0;
        end
        6: begin
          if (c == nsfc_pkg::CH_COMMA) kind_flags[nsfc_pkg::KF_COMMA] = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // accepted input item: update state, queue a report when one is due
    function void note_item(nsfc_pkg::in_item_t it);
      nsfc_pkg::out_item_t r;
      bit                  produced;
      bit                  ok;
      r        = '0;
      produced = 0;
      if (it.line_fault) begin
        r.status      = nsfc_pkg::STATUS_FAULT;
        r.line_length = in_sentence ? 7'(held) : 7'd0;
        in_sentence   = 0;
        held          = 0;
        fault_total++;
        produced = 1;
      end else if (it.rx_byte == nsfc_pkg::CH_DOLLAR) begin
        in_sentence = 1;
        held        = 1;
        xor_acc     = '0;
        star_seen   = 0;
        digits      = 0;
        sum_field   = '0;
        digits_ok   = 1;
        text_done   = 0;
        kind_flags  = '0;
      end else if (!in_sentence || it.rx_byte == nsfc_pkg::CH_CR) begin
        produced = 0;
      end else if (it.rx_byte == nsfc_pkg::CH_LF) begin
        ok = star_seen && digits == 2 && digits_ok && xor_acc == sum_field;
        r.line_length  = 7'(held);
        r.computed_sum = xor_acc;
        in_sentence    = 0;
        held           = 0;
        if (!ok) begin
          r.status = nsfc_pkg::STATUS_BAD_SUM;
          bad_total++;
        end else begin
          r.status        = nsfc_pkg::STATUS_OK;
          r.sentence_kind = nsfc_pkg::KIND_OTHER;
          if (kind_flags[nsfc_pkg::KF_COMMA]) begin
            if (kind_flags[nsfc_pkg::KF_GGA]) r.sentence_kind = nsfc_pkg::KIND_GGA;
            else if (kind_flags[nsfc_pkg::KF_RMC]) r.sentence_kind = nsfc_pkg::KIND_RMC;
          end
        end
        produced = 1;
      end else if (held < LINE_LIMIT) begin
        store_char(it.rx_byte);
      end else begin
        r.status      = nsfc_pkg::STATUS_OVERFLOW;
        r.line_length = 7'(held);
        in_sentence   = 0;
        held          = 0;
        overflow_total++;
        produced = 1;
      end
      if (produced) begin
        r.bad_sum_count = bad_total;
        r.drop_count    = overflow_total;
        r.fault_count   = fault_total;
        pending_reports.push_back(r);
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // accepted result item against the oldest owed report
    function void check_report(nsfc_pkg::out_item_t got);
      nsfc_pkg::out_item_t want;
      if (pending_reports.size() == 0) begin
        $error("result with no report pending: status %0d", got.status);
        mismatches++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("sentence_kind", 32'(want.sentence_kind), 32'(got.sentence_kind));
      compare_field("computed_sum", 32'(want.computed_sum), 32'(got.computed_sum));
      compare_field("line_length", 32'(want.line_length), 32'(got.line_length));
      compare_field("bad_sum_count", want.bad_sum_count, got.bad_sum_count);
      compare_field("drop_count", want.drop_count, got.drop_count);
      compare_field("fault_count", want.fault_count, got.fault_count);
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                item_valid;
  logic                item_stall;
  nsfc_pkg::in_item_t  item;
  logic                result_valid;
  logic                result_stall;
  nsfc_pkg::out_item_t result;

  sentence_predictor tracker;
  int unsigned       items_sent;
  int unsigned       idle_cycles;
  bit                steady;
  logic [7:0]        body_q[$];
  logic [7:0]        line_q[$];

  nmea_sentence_framer_checker #(
    .MAX_LINE_CHARS(LINE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // random result stall, none during the steady stretch
  always @(posedge clk) begin
    if (rst || steady) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(99) < 6);
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      tracker.check_report(result);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // send one item, with a random one-cycle gap before it outside the steady stretch
  task automatic send_item(input nsfc_pkg::in_item_t it);
    if (!steady && $urandom_range(99) < 6) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    tracker.note_item(it);
    items_sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    nsfc_pkg::in_item_t it;
    it.rx_byte    = c;
    it.line_fault = 1'b0;
    send_item(it);
  endtask

  // receiver error event; the character field carries junk
  task automatic send_fault();
    nsfc_pkg::in_item_t it;
    it.rx_byte    = 8'($urandom_range(255));
    it.line_fault = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 10) return CH_ZERO + 8'(n);
    return (lower ? CH_LOWER_A : nsfc_pkg::CH_A) + 8'(n) - 8'd10;
  endfunction

  // printable character that neither opens a sentence nor ends the text part
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126));
    while (c == nsfc_pkg::CH_DOLLAR || c == nsfc_pkg::CH_STAR);
    return c;
  endfunction

  // full sentence from the body queue, optional zero byte spliced in at nul_at
  task automatic send_sentence(input bit sum_good, input bit lower, input int nul_at);
    logic [7:0] sum;
    sum = '0;
    foreach (body_q[i]) sum ^= body_q[i];
    if (!sum_good) sum ^= 8'($urandom_range(1, 255));
    line_q.delete();
    line_q.push_back(nsfc_pkg::CH_DOLLAR);
    foreach (body_q[i]) line_q.push_back(body_q[i]);
    line_q.push_back(nsfc_pkg::CH_STAR);
    line_q.push_back(hex_char(sum[7:4], lower));
    line_q.push_back(hex_char(sum[3:0], lower));
    if ($urandom_range(1)) line_q.push_back(nsfc_pkg::CH_CR);
    line_q.push_back(nsfc_pkg::CH_LF);
    if (nul_at >= 0 && nul_at < line_q.size()) line_q.insert(nul_at, nsfc_pkg::CH_NUL);
    foreach (line_q[i]) send_char(line_q[i]);
    body_q.delete();
  endtask

  // sentence with random talker, kind, fields and digit case; its checksum is bad unless sum_good
  task automatic random_sentence(input bit sum_good, input int nul_at);
    int pick;
    pick = $urandom_range(2);
    repeat (2) body_q.push_back(nsfc_pkg::CH_A + 8'($urandom_range(25)));
    case (pick)
      0: push_text("GGA");
      1: push_text("RMC");
      default: repeat (3) body_q.push_back(nsfc_pkg::CH_A + 8'($urandom_range(25)));
    endcase
    if ($urandom_range(9) != 0) body_q.push_back(nsfc_pkg::CH_COMMA);
    repeat ($urandom_range(0, 30)) begin
      if ($urandom_range(19) == 0) body_q.push_back(8'($urandom_range(1, 255)));
      else body_q.push_back(text_char());
    end
    send_sentence(sum_good, $urandom_range(1), nul_at);
  endtask

  initial begin
    int pick;
    tracker      = new();
    items_sent   = 0;
    steady       = 1'b0;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item         <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed sentences: kinds, checksum faults, zero byte, faults, lengths
    push_text("GPGGA,123519,4807.038,N");
    send_sentence(1, 0, -1);
    push_text("GNRMC,081836,A");
    send_sentence(1, 1, -1);
    push_text("GPGSV,3,1");
    send_sentence(1, 0, -1);
    // kind word without the comma after it
    push_text("GPGGAX1");
    send_sentence(1, 0, -1);
    push_text("GPRMC,7");
    send_sentence(0, 0, -1);
    // no star, single digit, non-hex digit
    send_text("$GPRMC,1\r\n");
    send_text("$GPGGA*4\n");
    send_text("$AB*G1\n");
    // empty sentence and a star inside the kind word
    send_sentence(1, 0, -1);
    push_text("GP");
    send_sentence(1, 1, -1);
    // zero byte before the star, then after the digits
    push_text("GPGGA,1");
    send_sentence(1, 0, 4);
    push_text("GPRMC,9");
    send_sentence(1, 0, 11);
    // characters and newline outside a sentence
    send_text("xyz\n");
    send_char(8'hFF);
    // line faults with and without an open sentence
    send_fault();
    send_text("$GPG");
    send_fault();
    // dollar abandons a partial sentence
    send_text("$GPGG");
    push_text("GNGGA,5");
    send_sentence(1, 1, -1);
    // longest sentence that still fits
    repeat (LINE_LIMIT - 4) body_q.push_back(text_char());
    send_sentence(1, 0, -1);
    // characters past the line limit
    send_char(nsfc_pkg::CH_DOLLAR);
    repeat (LINE_LIMIT + 3) send_char(text_char());
    send_char(nsfc_pkg::CH_LF);

    // random traffic, mostly well-formed sentences
    while (items_sent < RANDOM_ITEMS) begin
      steady = (items_sent >= 700 && items_sent < 1000);
      pick = $urandom_range(99);
      if (pick < 65) begin
        random_sentence($urandom_range(9) < 8, -1);
      end else if (pick < 70) begin
        random_sentence(1, $urandom_range(1, 40));
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 10)) send_char(8'($urandom_range(255)));
      end else if (pick < 86) begin
        send_fault();
      end else if (pick < 93) begin
        // broken sentence, abandoned by whatever comes next
        send_char(nsfc_pkg::CH_DOLLAR);
        repeat ($urandom_range(0, 10)) send_char(text_char());
        if ($urandom_range(1)) send_char(nsfc_pkg::CH_STAR);
        if ($urandom_range(1)) send_char(hex_char(4'($urandom_range(15)), 0));
      end else if (pick < 97) begin
        send_char(nsfc_pkg::CH_DOLLAR);
        repeat ($urandom_range(LINE_LIMIT - 8, LINE_LIMIT + 8)) send_char(text_char());
        send_char(nsfc_pkg::CH_LF);
      end else begin
        send_char(nsfc_pkg::CH_DOLLAR);
        repeat ($urandom_range(0, 20)) send_char(8'($urandom_range(1, 255)));
        send_char(CH_UPPER_Z);
        send_char(nsfc_pkg::CH_LF);
      end
    end
    steady = 1'b0;
    item_valid <= 1'b0;

    // drain owed reports, then let the pipeline settle
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
